// ===== hdl/rgb2lab_pkg.sv =====
// rgb2lab_pkg: widths, fixed-point constants and the linearization table
// shared by the sRGB to CIELAB pipeline. No dependencies.
package rgb2lab_pkg;

	localparam int FRAC_BITS = 8;           // fractional bits of L, a, b
	localparam int QBITS     = 16;          // internal Q16 format
	localparam int RND_SH    = QBITS - FRAC_BITS;

	localparam int LIN_W  = 17;             // linear channel, Q16, up to 1.0
	localparam int TERM_W = 17;             // X/Y/Z and f(t), Q16
	localparam int NUMX_W = 33;
	localparam int NUMY_W = 30;
	localparam int NUMZ_W = 33;
	localparam int PROD_W = 57;
	localparam int RAW_W  = 28;             // signed L/a/b before rounding

	// sRGB matrix rows, pre-scaled by 10 for X and Z
	localparam int MX_R = 41240;
	localparam int MX_G = 35760;
	localparam int MX_B = 18050;
	localparam int MY_R = 2126;
	localparam int MY_G = 7152;
	localparam int MY_B = 722;
	localparam int MZ_R = 1930;
	localparam int MZ_G = 11920;
	localparam int MZ_B = 95050;

	localparam int X_DIV = 95047;
	localparam int Y_DIV = 10000;
	localparam int Z_DIV = 108883;
	localparam int X_RND = X_DIV / 2;
	localparam int Y_RND = Y_DIV / 2;
	localparam int Z_RND = Z_DIV / 2;

	// reciprocal divide: q_est = (n * RECIP) >> RECIP_SH is exact or one low
	localparam int RECIP_SH = 40;
	localparam logic [23:0] X_RECIP = 24'((64'd1 << RECIP_SH) / X_DIV);
	localparam logic [26:0] Y_RECIP = 27'((64'd1 << RECIP_SH) / Y_DIV);
	localparam logic [23:0] Z_RECIP = 24'((64'd1 << RECIP_SH) / Z_DIV);

	// f(t) linear segment: floor((903292 t + 1048576000 + 58000) / 116000)
	localparam int F_DIV    = 116000;
	localparam int F_SLOPE  = 903292;
	localparam int F_OFFSET = 1048576000 + 58000;
	localparam logic [23:0] F_RECIP = 24'((64'd1 << RECIP_SH) / F_DIV);
	localparam int F_CUBE_MIN = 580386816 / 1000000 + 1;  // t*1e6 > 580386816

	// cube root: two register stages per result bit
	localparam int F_STEPS = TERM_W;
	localparam int F_LAT   = 2 * F_STEPS;

	// top-level stages: lin, numerators, quotient estimate, XYZ, f, products, out
	localparam int PIPE_DEPTH = 4 + F_LAT + 2;

	localparam int L_MAX_I = ((100 << FRAC_BITS) > 32767) ? 32767 : (100 << FRAC_BITS);

	typedef logic [255:0][LIN_W-1:0] lin_tab_t;

	// elaboration-time helpers for the linearization table
	function automatic longint unsigned pow_chain(longint unsigned t, int n);
		longint unsigned p;
		p = t;
		for (int k = 1; k < n; k++) begin
			p = (p * t) >> QBITS;
		end
		return p;
	endfunction

	function automatic longint unsigned root_q(longint unsigned x, int n);
		longint unsigned t;
		longint unsigned cand;
		t = 0;
		for (int b = 16; b >= 0; b--) begin
			cand = t | (64'd1 << b);
			if (pow_chain(cand, n) <= x) begin
				t = cand;
			end
		end
		return t;
	endfunction

	function automatic longint unsigned lin_calc(longint unsigned c);
		longint unsigned v;
		longint unsigned v2;
		longint unsigned r;
		if (c <= 10) begin
			return (c * 6553600 + 164730) / 329460;
		end
		v  = ((1000 * c + 14025) * 65536 + 134512) / 269025;
		v2 = (v * v + 32768) >> QBITS;
		r  = root_q(v2, 5);
		return (v2 * r + 32768) >> QBITS;
	endfunction

	function automatic lin_tab_t lin_table_build();
		lin_tab_t tab;
		for (int c = 0; c < 256; c++) begin
			tab[c] = LIN_W'(lin_calc(longint'(c)));
		end
		return tab;
	endfunction

	localparam lin_tab_t LIN_TABLE = lin_table_build();

endpackage

// ===== hdl/rgb2lab_pix_if.sv =====
// rgb2lab_pix_if: valid/ready channel carrying one 8-bit sRGB pixel.
// No dependencies.
interface rgb2lab_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== hdl/rgb2lab_lab_if.sv =====
// rgb2lab_lab_if: valid/ready channel carrying one CIELAB result.
// No dependencies.
interface rgb2lab_lab_if;
	logic               valid;
	logic               ready;
	logic        [14:0] lightness;
	logic signed [15:0] green_red;
	logic signed [15:0] blue_yellow;

	modport source (output valid, output lightness, output green_red, output blue_yellow,
		input ready);
	modport sink   (input valid, input lightness, input green_red, input blue_yellow,
		output ready);
endinterface

// ===== hdl/rgb2lab_fcurve.sv =====
// rgb2lab_fcurve: CIELAB companding f(t), pipelined bit-by-bit cube root
// with the linear segment computed alongside. Depends on rgb2lab_pkg.
module rgb2lab_fcurve (
	input  logic                            clk,
	input  logic                            en,
	input  logic [rgb2lab_pkg::TERM_W-1:0]  t,
	output logic [rgb2lab_pkg::TERM_W-1:0]  f
);
	import rgb2lab_pkg::*;

	typedef struct packed {
		logic [TERM_W-1:0] t;
		logic [TERM_W-1:0] root;
		logic [30:0]       lin_n;
		logic [14:0]       lin_q;
		logic              cube;
	} fc_t;

	// per result bit: stage a squares the candidate, stage b cubes and compares
	fc_t         pipe_a_s [F_STEPS];
	logic [17:0] sq_a_s   [F_STEPS];
	fc_t         pipe_b_s [F_STEPS];

	for (genvar k = 0; k < F_STEPS; k++) begin : g_step
		localparam int BITPOS = F_STEPS - 1 - k;
		fc_t               src_a;
		fc_t               nxt_a;
		fc_t               nxt_b;
		logic [TERM_W-1:0] cand_a;
		logic [TERM_W-1:0] cand_b;
		logic [17:0]       sq_nxt;
		logic [18:0]       cube_v;
		logic [30:0]       rem;

		if (k == 0) begin : g_first
			always_comb begin
				src_a       = '0;
				src_a.t     = t;
				src_a.cube  = (t >= TERM_W'(F_CUBE_MIN));
			end
		end else begin : g_next
			assign src_a = pipe_b_s[k-1];
		end

		always_comb begin
			nxt_a  = src_a;
			rem    = '0;
			cand_a = src_a.root | (TERM_W'(1) << BITPOS);
			sq_nxt = 18'((34'(cand_a) * 34'(cand_a)) >> QBITS);
			if (k == 0) begin
				// linear segment numerator; t is below 581 whenever it is used
				nxt_a.lin_n = 31'(F_SLOPE) * 31'(src_a.t[9:0]) + 31'(F_OFFSET);
			end
			if (k == 1) begin
				// reciprocal estimate is at most one low
				rem = src_a.lin_n - 31'(src_a.lin_q) * 31'(F_DIV);
				if (rem >= 31'(F_DIV)) begin
					nxt_a.lin_q = src_a.lin_q + 15'd1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_a_s[k] <= nxt_a;
				sq_a_s[k]   <= sq_nxt;
			end
		end

		always_comb begin
			nxt_b  = pipe_a_s[k];
			cand_b = pipe_a_s[k].root | (TERM_W'(1) << BITPOS);
			cube_v = 19'((35'(sq_a_s[k]) * 35'(cand_b)) >> QBITS);
			if (cube_v <= 19'(pipe_a_s[k].t)) begin
				nxt_b.root = cand_b;
			end
			if (k == 0) begin
				nxt_b.lin_q = 15'((55'(pipe_a_s[k].lin_n) * 55'(F_RECIP)) >> RECIP_SH);
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_b_s[k] <= nxt_b;
			end
		end
	end

	assign f = pipe_b_s[F_STEPS-1].cube ? pipe_b_s[F_STEPS-1].root
		: TERM_W'(pipe_b_s[F_STEPS-1].lin_q);

endmodule

// ===== hdl/rgb_to_lab_converter_core.sv =====
// rgb_to_lab_converter_core: sRGB pixel to CIELAB (D65) pipeline.
// Depends on rgb2lab_pkg, rgb2lab_pix_if, rgb2lab_lab_if, rgb2lab_fcurve.
//
// Usage:
//  - pix_in carries one 8-bit sRGB pixel per beat; lab_out carries L (Q.8,
//    0..100), a and b (signed Q.8, saturated to 16 bits), one beat per pixel.
//  - Fully pipelined: one pixel per clock sustained while lab_out is not
//    stalled. A pixel passes through 40 register stages on its way to
//    lab_out. The depth is set by the cube root, which resolves one result
//    bit every two stages (34 stages), plus 6 stages of table lookup,
//    matrix, constant division and final scaling.
//  - Stall: when lab_out holds a beat that is not taken, the whole pipeline
//    freezes and pix_in.ready drops; nothing is lost or repeated. While the
//    output stage is empty or being drained, a new pixel is taken every
//    cycle.
//  - Reset (arst_n low) clears all valid bits; payload registers are left
//    as they are. No configuration, no state between pixels.
module rgb_to_lab_converter_core (
	input  logic          clk,
	input  logic          arst_n,
	rgb2lab_pix_if.sink   pix_in,
	rgb2lab_lab_if.source lab_out
);
	import rgb2lab_pkg::*;

	logic                   adv;
	logic [PIPE_DEPTH-1:0]  vld_q;

	// stage 1: linearized channels from the constant table
	logic [LIN_W-1:0]  lin_r_s1, lin_g_s1, lin_b_s1;
	// stage 2: matrix numerators with rounding offset
	logic [NUMX_W-1:0] num_x_s2;
	logic [NUMY_W-1:0] num_y_s2;
	logic [NUMZ_W-1:0] num_z_s2;
	// stage 3: quotient estimates
	logic [NUMX_W-1:0] num_x_s3;
	logic [NUMY_W-1:0] num_y_s3;
	logic [NUMZ_W-1:0] num_z_s3;
	logic [TERM_W-1:0] qe_x_s3, qe_y_s3, qe_z_s3;
	// stage 4: normalized X, Y, Z
	logic [TERM_W-1:0] x_s4, y_s4, z_s4;
	// f outputs, aligned with the last cube root stage
	logic [TERM_W-1:0] fx, fy, fz;
	// stage 5: scaled L, a, b before rounding
	logic signed [RAW_W-1:0] l_raw_s5, a_raw_s5, b_raw_s5;
	// stage 6: output register
	logic        [14:0] lightness_s6;
	logic signed [15:0] green_red_s6, blue_yellow_s6;

	logic [NUMX_W-1:0] num_x;
	logic [NUMY_W-1:0] num_y;
	logic [NUMZ_W-1:0] num_z;
	logic [NUMX_W-1:0] rem_x;
	logic [NUMY_W-1:0] rem_y;
	logic [NUMZ_W-1:0] rem_z;
	logic signed [17:0] dif_a, dif_b;
	logic signed [RAW_W-1:0] l_rnd, a_rnd, b_rnd;
	logic signed [RAW_W-1:0] l_clip, a_sat, b_sat;

	localparam logic signed [RAW_W-1:0] SAT_HI = RAW_W'(32767);
	localparam logic signed [RAW_W-1:0] SAT_LO = -RAW_W'(32768);
	localparam logic signed [RAW_W-1:0] L_MAX  = RAW_W'(L_MAX_I);
	localparam logic signed [RAW_W-1:0] L_OFS  = RAW_W'(16 << QBITS);

	// signed round to nearest, ties away from zero
	function automatic logic signed [RAW_W-1:0] round_away(input logic signed [RAW_W-1:0] v);
		logic             neg;
		logic [RAW_W-1:0] mag;
		neg = v[RAW_W-1];
		mag = neg ? RAW_W'(-v) : RAW_W'(v);
		mag = (mag + (RAW_W'(1) << (RND_SH - 1))) >> RND_SH;
		return neg ? -signed'(mag) : signed'(mag);
	endfunction

	function automatic logic signed [RAW_W-1:0] sat16(input logic signed [RAW_W-1:0] v);
		if (v > SAT_HI) begin
			return SAT_HI;
		end
		if (v < SAT_LO) begin
			return SAT_LO;
		end
		return v;
	endfunction

	// global advance: the pipe moves unless the output holds an untaken beat
	assign adv          = !vld_q[PIPE_DEPTH-1] || lab_out.ready;
	assign pix_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], pix_in.valid};
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (adv) begin
			lin_r_s1 <= LIN_TABLE[pix_in.red];
			lin_g_s1 <= LIN_TABLE[pix_in.green];
			lin_b_s1 <= LIN_TABLE[pix_in.blue];
		end
	end

	// stage 2: constant-coefficient matrix
	always_comb begin
		num_x = NUMX_W'(MX_R) * NUMX_W'(lin_r_s1) + NUMX_W'(MX_G) * NUMX_W'(lin_g_s1)
			+ NUMX_W'(MX_B) * NUMX_W'(lin_b_s1) + NUMX_W'(X_RND);
		num_y = NUMY_W'(MY_R) * NUMY_W'(lin_r_s1) + NUMY_W'(MY_G) * NUMY_W'(lin_g_s1)
			+ NUMY_W'(MY_B) * NUMY_W'(lin_b_s1) + NUMY_W'(Y_RND);
		num_z = NUMZ_W'(MZ_R) * NUMZ_W'(lin_r_s1) + NUMZ_W'(MZ_G) * NUMZ_W'(lin_g_s1)
			+ NUMZ_W'(MZ_B) * NUMZ_W'(lin_b_s1) + NUMZ_W'(Z_RND);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_x_s2 <= num_x;
			num_y_s2 <= num_y;
			num_z_s2 <= num_z;
		end
	end

	// stage 3: reciprocal multiply, estimate exact or one low
	always_ff @(posedge clk) begin
		if (adv) begin
			num_x_s3 <= num_x_s2;
			num_y_s3 <= num_y_s2;
			num_z_s3 <= num_z_s2;
			qe_x_s3  <= TERM_W'((PROD_W'(num_x_s2) * PROD_W'(X_RECIP)) >> RECIP_SH);
			qe_y_s3  <= TERM_W'((PROD_W'(num_y_s2) * PROD_W'(Y_RECIP)) >> RECIP_SH);
			qe_z_s3  <= TERM_W'((PROD_W'(num_z_s2) * PROD_W'(Z_RECIP)) >> RECIP_SH);
		end
	end

	// stage 4: remainder check fixes the estimate
	always_comb begin
		rem_x = num_x_s3 - NUMX_W'(qe_x_s3) * NUMX_W'(X_DIV);
		rem_y = num_y_s3 - NUMY_W'(qe_y_s3) * NUMY_W'(Y_DIV);
		rem_z = num_z_s3 - NUMZ_W'(qe_z_s3) * NUMZ_W'(Z_DIV);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s4 <= (rem_x >= NUMX_W'(X_DIV)) ? qe_x_s3 + TERM_W'(1) : qe_x_s3;
			y_s4 <= (rem_y >= NUMY_W'(Y_DIV)) ? qe_y_s3 + TERM_W'(1) : qe_y_s3;
			z_s4 <= (rem_z >= NUMZ_W'(Z_DIV)) ? qe_z_s3 + TERM_W'(1) : qe_z_s3;
		end
	end

	// f(t) for each term, F_LAT stages
	rgb2lab_fcurve u_fx (.clk(clk), .en(adv), .t(x_s4), .f(fx));
	rgb2lab_fcurve u_fy (.clk(clk), .en(adv), .t(y_s4), .f(fy));
	rgb2lab_fcurve u_fz (.clk(clk), .en(adv), .t(z_s4), .f(fz));

	// stage 5: L = 116 fy - 16, a = 500 (fx - fy), b = 200 (fy - fz), in Q16
	assign dif_a = $signed({1'b0, fx}) - $signed({1'b0, fy});
	assign dif_b = $signed({1'b0, fy}) - $signed({1'b0, fz});

	always_ff @(posedge clk) begin
		if (adv) begin
			l_raw_s5 <= signed'(RAW_W'(fy)) * RAW_W'(116) - L_OFS;
			a_raw_s5 <= RAW_W'(dif_a) * RAW_W'(500);
			b_raw_s5 <= RAW_W'(dif_b) * RAW_W'(200);
		end
	end

	// stage 6: round to FRAC_BITS, clamp L, saturate a and b
	always_comb begin
		l_rnd  = round_away(l_raw_s5);
		a_rnd  = round_away(a_raw_s5);
		b_rnd  = round_away(b_raw_s5);
		a_sat  = sat16(a_rnd);
		b_sat  = sat16(b_rnd);
		l_clip = l_rnd;
		if (l_rnd[RAW_W-1]) begin
			l_clip = '0;
		end else if (l_rnd > L_MAX) begin
			l_clip = L_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lightness_s6   <= l_clip[14:0];
			green_red_s6   <= a_sat[15:0];
			blue_yellow_s6 <= b_sat[15:0];
		end
	end

	assign lab_out.valid       = vld_q[PIPE_DEPTH-1];
	assign lab_out.lightness   = lightness_s6;
	assign lab_out.green_red   = green_red_s6;
	assign lab_out.blue_yellow = blue_yellow_s6;

endmodule

// ===== hdl/rgb2lab_checker.sv =====
// rgb2lab_checker: port-level assertions for rgb_to_lab_converter_core,
// attached by bind. Depends on rgb2lab_pkg.
module rgb2lab_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic        [14:0] lightness,
	input logic signed [15:0] green_red,
	input logic signed [15:0] blue_yellow
);
	import rgb2lab_pkg::*;

	// a held beat stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("lab_out beat dropped while stalled");

	// a held beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(lightness) && $stable(green_red)
			&& $stable(blue_yellow))
		else $error("lab_out payload changed while stalled");

	// the pipe only pushes back when the output beat is held
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("pix_in stalled with free output");

	// lightness is clamped to 100
	a_l_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lightness <= 15'(L_MAX_I))
		else $error("lightness out of range");

endmodule

bind rgb_to_lab_converter_core rgb2lab_checker u_rgb2lab_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (pix_in.ready),
	.out_valid   (lab_out.valid),
	.out_ready   (lab_out.ready),
	.lightness   (lab_out.lightness),
	.green_red   (lab_out.green_red),
	.blue_yellow (lab_out.blue_yellow)
);
